>>> sv/mlc_pkg.sv
// ----------------------------------------------------------------------------
// mlc_pkg
// types and codes shared by the l1 mesi line controller modules
// ----------------------------------------------------------------------------
`default_nettype none
package mlc_pkg;

  // event codes
  localparam logic [3:0] OP_GETS      = 4'd0;
  localparam logic [3:0] OP_GETX      = 4'd1;
  localparam logic [3:0] OP_GETSEX    = 4'd2;
  localparam logic [3:0] OP_FLUSH     = 4'd3;
  localparam logic [3:0] OP_FLUSHINV  = 4'd4;
  localparam logic [3:0] OP_INV       = 4'd5;
  localparam logic [3:0] OP_FETCH     = 4'd6;
  localparam logic [3:0] OP_FETCHINV  = 4'd7;
  localparam logic [3:0] OP_FETCHINVX = 4'd8;
  localparam logic [3:0] OP_DATARESP  = 4'd9;
  localparam logic [3:0] OP_ACKPUT    = 4'd10;
  localparam logic [3:0] OP_FLUSHRESP = 4'd11;
  localparam logic [3:0] OP_EVICT     = 4'd12;

  // line states
  localparam logic [3:0] LS_I  = 4'd0;
  localparam logic [3:0] LS_S  = 4'd1;
  localparam logic [3:0] LS_E  = 4'd2;
  localparam logic [3:0] LS_M  = 4'd3;
  localparam logic [3:0] LS_IS = 4'd4;
  localparam logic [3:0] LS_IM = 4'd5;
  localparam logic [3:0] LS_SM = 4'd6;
  localparam logic [3:0] LS_SB = 4'd7;
  localparam logic [3:0] LS_IB = 4'd8;

  localparam logic [1:0] ACT_DONE   = 2'd0;
  localparam logic [1:0] ACT_STALL  = 2'd1;
  localparam logic [1:0] ACT_IGNORE = 2'd2;

  localparam logic [3:0] DN_NONE      = 4'd0;
  localparam logic [3:0] DN_PUTS      = 4'd1;
  localparam logic [3:0] DN_PUTE      = 4'd2;
  localparam logic [3:0] DN_PUTM      = 4'd3;
  localparam logic [3:0] DN_ACKINV    = 4'd4;
  localparam logic [3:0] DN_FETCHRESP = 4'd5;
  localparam logic [3:0] DN_FLUSH     = 4'd6;
  localparam logic [3:0] DN_FLUSHINV  = 4'd7;
  localparam logic [3:0] DN_MISS      = 4'd8;

  localparam logic [1:0] UP_NONE  = 2'd0;
  localparam logic [1:0] UP_READ  = 2'd1;
  localparam logic [1:0] UP_WRITE = 2'd2;
  localparam logic [1:0] UP_FLUSH = 2'd3;

  localparam logic [1:0] NOTE_NONE = 2'd0;
  localparam logic [1:0] NOTE_HIT  = 2'd1;
  localparam logic [1:0] NOTE_MISS = 2'd2;

  localparam logic [1:0] ORIG_GETX = 2'd1;
  localparam logic [1:0] GS_E      = 2'd1;
  localparam logic [1:0] GS_M      = 2'd2;

  localparam logic [1:0] CFG_SILENT_EVICT = 2'd0;
  localparam logic [1:0] CFG_EXPECT_WBACK = 2'd1;
  localparam logic [1:0] CFG_SNOOP_INV    = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] line_index;
    logic       line_present;
    logic [1:0] orig_request;
    logic       own_prefetch;
    logic       load_link;
    logic       store_conditional;
    logic       store_unlock;
    logic [1:0] granted_state;
    logic       request_pending;
    logic       flush_success;
  } in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] down_message;
    logic       down_dirty;
    logic [1:0] up_message;
    logic       up_success;
    logic       up_snoop;
    logic [1:0] access_note;
    logic [3:0] new_line_state;
    logic       lock_waiter_set;
    logic       error;
  } out_t;

  typedef struct packed {
    logic [3:0] state;
    logic [7:0] lock_count;
    logic       link_flag;
    logic       waiting_for_lock;
    logic       writeback_pending;
  } entry_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  typedef struct packed {
    logic clr_we;
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/mlc_ctrl.sv
// ----------------------------------------------------------------------------
// mlc_ctrl
// sequencer: clearing pass, request capture and line update
// ----------------------------------------------------------------------------
`default_nettype none
module mlc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire mlc_pkg::sts_t sts,
  output mlc_pkg::cmd_t     cmd
);
  import mlc_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      FSM_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clear_last) state_nxt = FSM_IDLE;
      end
      FSM_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/mlc_dpath.sv
// ----------------------------------------------------------------------------
// mlc_dpath
// line table, config registers and the coherence update logic
// ----------------------------------------------------------------------------
`default_nettype none
module mlc_dpath #(
  parameter int LINES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mlc_pkg::cmd_t cmd,
  output mlc_pkg::sts_t      sts,
  input  wire mlc_pkg::in_t  in_req,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic          cfg_wdata,
  output logic               out_valid,
  output mlc_pkg::out_t      out_res
);
  import mlc_pkg::*;

  localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [IW-1:0] LAST = IW'(LINES - 1);

  entry_t        mem [LINES];
  logic [IW-1:0] idx_tab [256];
  logic [IW-1:0] idx_in;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] clr_cnt_r;
  in_t           req_r;
  entry_t        ent_r;
  entry_t        ent_nxt;
  out_t          res;
  out_t          out_r;
  logic          out_valid_r;
  logic          silent_r, expect_r, snoop_r;

  // line index folded onto the table depth, constants only
  for (genvar v = 0; v < 256; v++) begin : g_fold
    assign idx_tab[v] = IW'(v % LINES);
  end
  assign idx_in = idx_tab[in_req.line_index];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silent_r <= 1'b0;
      expect_r <= 1'b0;
      snoop_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SILENT_EVICT: silent_r <= cfg_wdata;
        CFG_EXPECT_WBACK: expect_r <= cfg_wdata;
        CFG_SNOOP_INV:    snoop_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end
  assign sts.clear_last = (clr_cnt_r == LAST);

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.exec) begin
      mem[idx_r] <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
      idx_r <= idx_in;
      ent_r <= mem[idx_in];
    end
  end

  always_comb begin
    logic [3:0] st, cur, nst;
    logic       pres, shown, locked, err, exempt;
    logic [1:0] act, up, note;
    logic [3:0] dn;
    logic       dd, us, snp, lw;
    st     = ent_r.state;
    pres   = req_r.line_present;
    cur    = pres ? st : LS_I;
    nst    = st;
    shown  = pres;
    locked = (ent_r.lock_count != 8'd0);
    err    = 1'b0;
    act    = ACT_DONE;
    up     = UP_NONE;
    note   = NOTE_NONE;
    dn     = DN_NONE;
    dd     = 1'b0;
    us     = 1'b0;
    snp    = 1'b0;
    lw     = 1'b0;
    ent_nxt = ent_r;
    case (req_r.op)
      OP_GETS: begin
        shown = 1'b1;
        if (cur == LS_I) begin
          dn = DN_MISS; note = NOTE_MISS; nst = LS_IS; act = ACT_STALL;
        end else if (cur == LS_S || cur == LS_E || cur == LS_M) begin
          note = NOTE_HIT; nst = cur;
          if (!req_r.own_prefetch) begin
            if (req_r.load_link) ent_nxt.link_flag = 1'b1;
            up = UP_READ;
          end
        end else err = 1'b1;
      end
      OP_GETX, OP_GETSEX: begin
        shown = 1'b1;
        if (cur == LS_I) begin
          dn = DN_MISS; note = NOTE_MISS; nst = LS_IM; act = ACT_STALL;
        end else if (cur == LS_S) begin
          dn = DN_MISS; note = NOTE_MISS; nst = LS_SM; act = ACT_STALL;
        end else if (cur == LS_E || cur == LS_M) begin
          nst = LS_M; note = NOTE_HIT;
          if (req_r.op == OP_GETX) begin
            if (req_r.store_unlock) begin
              if (!locked) err = 1'b1;
              else ent_nxt.lock_count = ent_r.lock_count - 8'd1;
            end
            up = UP_WRITE;
            us = req_r.store_conditional & ent_r.link_flag;
          end else begin
            if (ent_r.lock_count != 8'hff) ent_nxt.lock_count = ent_r.lock_count + 8'd1;
            up = UP_READ;
          end
        end else err = 1'b1;
      end
      OP_FLUSH, OP_FLUSHINV: begin
        if (cur != LS_I && cur >= LS_IS) act = ACT_STALL;
        else if (req_r.request_pending) act = ACT_STALL;
        else if (cur != LS_I && locked) up = UP_FLUSH;
        else begin
          dn = (req_r.op == OP_FLUSH) ? DN_FLUSH : DN_FLUSHINV;
          dd = pres && (cur == LS_M);
          if (pres) nst = (req_r.op == OP_FLUSH && cur != LS_I) ? LS_SB : LS_IB;
          act = ACT_STALL;
        end
      end
      OP_INV, OP_FETCH, OP_FETCHINV, OP_FETCHINVX: begin
        if (!pres) begin
          if (ent_r.writeback_pending) ent_nxt.writeback_pending = 1'b0;
          else act = ACT_IGNORE;
        end else begin
          if (req_r.op != OP_INV && locked) begin
            lw = 1'b1; act = ACT_STALL;
          end else if (req_r.op == OP_INV) begin
            if (st == LS_S) begin
              dn = DN_ACKINV; nst = LS_I;
            end else if (st == LS_SM) begin
              dn = DN_ACKINV; nst = LS_IM;
            end else if (st == LS_SB) begin
              dn = DN_ACKINV; nst = LS_IB; act = ACT_IGNORE;
            end else if (st == LS_E || st == LS_M) err = 1'b1;
            else act = ACT_IGNORE;
          end else if (req_r.op == OP_FETCH) begin
            if (st == LS_S || st == LS_SM) dn = DN_FETCHRESP;
            else if (st == LS_E || st == LS_M) err = 1'b1;
            else act = ACT_IGNORE;
          end else if (req_r.op == OP_FETCHINV) begin
            if (st == LS_SM) begin
              dn = DN_FETCHRESP; nst = LS_IM;
            end else if (st == LS_S || st == LS_E || st == LS_M) begin
              dn = DN_FETCHRESP; dd = (st == LS_M); nst = LS_I;
            end else if (st == LS_SB) begin
              dn = DN_ACKINV; nst = LS_IB; act = ACT_IGNORE;
            end else act = ACT_IGNORE;
          end else begin
            if (st == LS_E || st == LS_M) begin
              dn = DN_FETCHRESP; dd = (st == LS_M); nst = LS_S;
            end else if (st == LS_S) err = 1'b1;
            else act = ACT_IGNORE;
          end
          if (!err) begin
            snp = snoop_r;
            ent_nxt.link_flag = 1'b0;
            if (lw) ent_nxt.waiting_for_lock = 1'b1;
          end
        end
      end
      OP_DATARESP: begin
        if (!pres) err = 1'b1;
        else if (st == LS_IS) begin
          nst = (req_r.granted_state == GS_E) ? LS_E :
                (req_r.granted_state == GS_M) ? LS_M : LS_S;
          note = NOTE_HIT;
          if (!req_r.own_prefetch) begin
            if (req_r.load_link) ent_nxt.link_flag = 1'b1;
            up = UP_READ;
          end
        end else if (st == LS_IM || st == LS_SM) begin
          nst = LS_M; note = NOTE_HIT;
          if (req_r.orig_request == ORIG_GETX) begin
            if (req_r.store_unlock) begin
              if (!locked) err = 1'b1;
              else ent_nxt.lock_count = ent_r.lock_count - 8'd1;
            end
            up = UP_WRITE;
            us = req_r.store_conditional & ent_r.link_flag;
          end else begin
            if (ent_r.lock_count != 8'hff) ent_nxt.lock_count = ent_r.lock_count + 8'd1;
            up = UP_READ;
          end
        end else err = 1'b1;
      end
      OP_ACKPUT: begin
        ent_nxt.writeback_pending = 1'b0;
      end
      OP_FLUSHRESP: begin
        if (pres) begin
          if (st == LS_SB) nst = LS_S;
          else if (st == LS_IB) nst = LS_I;
        end
        up = UP_FLUSH; us = req_r.flush_success;
      end
      OP_EVICT: begin
        if (pres) begin
          if (locked) begin
            ent_nxt.waiting_for_lock = 1'b1; lw = 1'b1; act = ACT_STALL;
          end else if (st == LS_S || st == LS_E || st == LS_M) begin
            if (st == LS_M) begin
              dn = DN_PUTM; dd = 1'b1;
            end else if (!silent_r) dn = (st == LS_S) ? DN_PUTS : DN_PUTE;
            if (expect_r) ent_nxt.writeback_pending = 1'b1;
            nst = LS_I;
          end else if (st >= LS_IS && st <= LS_IB) act = ACT_STALL;
          else if (st != LS_I) err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase
    // an unlock of an unlocked line keeps the normal write handling
    exempt = (req_r.op == OP_GETX && (cur == LS_E || cur == LS_M)) ||
             (req_r.op == OP_DATARESP && pres && (st == LS_IM || st == LS_SM));
    if (err && !exempt) begin
      act = ACT_IGNORE; dn = DN_NONE; dd = 1'b0; up = UP_NONE; us = 1'b0;
      snp = 1'b0; note = NOTE_NONE; lw = 1'b0; nst = st;
    end
    ent_nxt.state = nst;
    res.action          = act;
    res.down_message    = dn;
    res.down_dirty      = dd;
    res.up_message      = up;
    res.up_success      = us;
    res.up_snoop        = snp;
    res.access_note     = note;
    res.new_line_state  = shown ? nst : LS_I;
    res.lock_waiter_set = lw;
    res.error           = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire

>>> sv/l1_mesi_line_controller_top.sv
// ----------------------------------------------------------------------------
// l1_mesi_line_controller_top
// per-line mesi coherence controller: one event in, one result out
// ----------------------------------------------------------------------------
// a taken request is registered at capture; the update state then registers its result and strobe
// busy stays high through the line update, so a new request waits until the last is done
// reset: synchronous; after rst_n a pass clearing all LINES entries holds busy high
// results are a one-cycle strobe on out_valid; the receiver cannot stall
`default_nettype none
module l1_mesi_line_controller_top #(
  parameter int LINES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire mlc_pkg::in_t  in_req,
  output logic               out_valid,
  output mlc_pkg::out_t      out_res,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic          cfg_wdata
);
  import mlc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mlc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mlc_dpath #(.LINES(LINES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// l1 mesi line controller: each request is predicted against a per-line
// coherence table held here, and every result strobe is checked in order
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mlc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_req = '0;
  logic out_valid;
  out_t out_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic cfg_wdata = 1'b0;

  l1_mesi_line_controller_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // line table copy
  logic [3:0] line_st [256];
  logic [7:0] locks [256];
  logic link_f [256];
  logic lock_wait [256];
  logic wb_pend [256];
  logic silent_evict, expect_wback, snoop_inv;

  out_t result_q [$];
  int errors = 0;
  int cycles = 0;
  int gap_pct = 35;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, out_res);
        errors++;
      end else begin
        out_t e;
        e = result_q.pop_front();
        if (e !== out_res) begin
          $display("%0t mismatch expected %h actual %h", $realtime, e, out_res);
          errors++;
        end
      end
    end
  end

  function automatic out_t coherence_step(in_t r);
    out_t o;
    logic [7:0] i;
    logic [3:0] st, cur, nst;
    logic present, shown, locked, err;
    o = '0;
    i = r.line_index;
    present = r.line_present;
    st = line_st[i];
    cur = present ? st : LS_I;
    nst = st;
    shown = present;
    locked = locks[i] != 0;
    err = 1'b0;
    o.action = ACT_DONE;
    case (r.op)
      OP_GETS: begin
        shown = 1'b1;
        if (cur == LS_I) begin
          o.down_message = DN_MISS; o.access_note = NOTE_MISS; nst = LS_IS;
          o.action = ACT_STALL;
        end else if (cur == LS_S || cur == LS_E || cur == LS_M) begin
          o.access_note = NOTE_HIT; nst = cur;
          if (!r.own_prefetch) begin
            if (r.load_link) link_f[i] = 1'b1;
            o.up_message = UP_READ;
          end
        end else err = 1'b1;
      end
      OP_GETX, OP_GETSEX: begin
        shown = 1'b1;
        if (cur == LS_I || cur == LS_S) begin
          o.down_message = DN_MISS; o.access_note = NOTE_MISS;
          nst = (cur == LS_I) ? LS_IM : LS_SM; o.action = ACT_STALL;
        end else if (cur == LS_E || cur == LS_M) begin
          nst = LS_M; o.access_note = NOTE_HIT;
          if (r.op == OP_GETX) begin
            if (r.store_unlock) begin
              if (!locked) err = 1'b1;
              else locks[i]--;
            end
            o.up_message = UP_WRITE;
            o.up_success = r.store_conditional ? link_f[i] : 1'b0;
          end else begin
            if (locks[i] != 8'hff) locks[i]++;
            o.up_message = UP_READ;
          end
        end else err = 1'b1;
      end
      OP_FLUSH, OP_FLUSHINV: begin
        if (cur != LS_I && cur >= LS_IS) o.action = ACT_STALL;
        else if (r.request_pending) o.action = ACT_STALL;
        else if (cur != LS_I && locked) o.up_message = UP_FLUSH;
        else begin
          o.down_message = (r.op == OP_FLUSH) ? DN_FLUSH : DN_FLUSHINV;
          o.down_dirty = present && cur == LS_M;
          if (present) nst = (r.op == OP_FLUSH && cur != LS_I) ? LS_SB : LS_IB;
          o.action = ACT_STALL;
        end
      end
      OP_INV, OP_FETCH, OP_FETCHINV, OP_FETCHINVX: begin
        if (!present) begin
          if (wb_pend[i]) wb_pend[i] = 1'b0;
          else o.action = ACT_IGNORE;
        end else begin
          if (r.op != OP_INV && locked) begin
            o.lock_waiter_set = 1'b1; o.action = ACT_STALL;
          end else if (r.op == OP_INV) begin
            if (st == LS_S) begin o.down_message = DN_ACKINV; nst = LS_I; end
            else if (st == LS_SM) begin o.down_message = DN_ACKINV; nst = LS_IM; end
            else if (st == LS_SB) begin
              o.down_message = DN_ACKINV; nst = LS_IB; o.action = ACT_IGNORE;
            end else if (st == LS_E || st == LS_M) err = 1'b1;
            else o.action = ACT_IGNORE;
          end else if (r.op == OP_FETCH) begin
            if (st == LS_S || st == LS_SM) o.down_message = DN_FETCHRESP;
            else if (st == LS_E || st == LS_M) err = 1'b1;
            else o.action = ACT_IGNORE;
          end else if (r.op == OP_FETCHINV) begin
            if (st == LS_SM) begin o.down_message = DN_FETCHRESP; nst = LS_IM; end
            else if (st == LS_S || st == LS_E || st == LS_M) begin
              o.down_message = DN_FETCHRESP; o.down_dirty = st == LS_M; nst = LS_I;
            end else if (st == LS_SB) begin
              o.down_message = DN_ACKINV; nst = LS_IB; o.action = ACT_IGNORE;
            end else o.action = ACT_IGNORE;
          end else begin
            if (st == LS_E || st == LS_M) begin
              o.down_message = DN_FETCHRESP; o.down_dirty = st == LS_M; nst = LS_S;
            end else if (st == LS_S) err = 1'b1;
            else o.action = ACT_IGNORE;
          end
          if (!err) begin
            o.up_snoop = snoop_inv;
            link_f[i] = 1'b0;
            if (o.lock_waiter_set) lock_wait[i] = 1'b1;
          end
        end
      end
      OP_DATARESP: begin
        if (!present) err = 1'b1;
        else if (st == LS_IS) begin
          nst = (r.granted_state == GS_E) ? LS_E : (r.granted_state == GS_M) ? LS_M : LS_S;
          o.access_note = NOTE_HIT;
          if (!r.own_prefetch) begin
            if (r.load_link) link_f[i] = 1'b1;
            o.up_message = UP_READ;
          end
        end else if (st == LS_IM || st == LS_SM) begin
          nst = LS_M; o.access_note = NOTE_HIT;
          if (r.orig_request == ORIG_GETX) begin
            if (r.store_unlock) begin
              if (!locked) err = 1'b1;
              else locks[i]--;
            end
            o.up_message = UP_WRITE;
            o.up_success = r.store_conditional ? link_f[i] : 1'b0;
          end else begin
            if (locks[i] != 8'hff) locks[i]++;
            o.up_message = UP_READ;
          end
        end else err = 1'b1;
      end
      OP_ACKPUT: wb_pend[i] = 1'b0;
      OP_FLUSHRESP: begin
        if (present) begin
          if (st == LS_SB) nst = LS_S;
          else if (st == LS_IB) nst = LS_I;
        end
        o.up_message = UP_FLUSH; o.up_success = r.flush_success;
      end
      OP_EVICT: begin
        if (present) begin
          if (locked) begin
            lock_wait[i] = 1'b1; o.lock_waiter_set = 1'b1; o.action = ACT_STALL;
          end else if (st == LS_S || st == LS_E || st == LS_M) begin
            if (st == LS_M) begin o.down_message = DN_PUTM; o.down_dirty = 1'b1; end
            else if (!silent_evict) o.down_message = (st == LS_S) ? DN_PUTS : DN_PUTE;
            if (expect_wback) wb_pend[i] = 1'b1;
            nst = LS_I;
          end else if (st >= LS_IS && st <= LS_IB) o.action = ACT_STALL;
          else if (st != LS_I) err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase
    // unlock of an unlocked line keeps the rest of the write
    if (err && !((r.op == OP_GETX && (cur == LS_E || cur == LS_M)) ||
        (r.op == OP_DATARESP && present && (st == LS_IM || st == LS_SM)))) begin
      o = '0;
      o.action = ACT_IGNORE;
      nst = st;
    end
    o.error = err;
    line_st[i] = nst;
    o.new_line_state = shown ? nst : LS_I;
    return o;
  endfunction

  task automatic send_request(in_t r);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    result_q.push_back(coherence_step(r));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_SILENT_EVICT: silent_evict = v;
      CFG_EXPECT_WBACK: expect_wback = v;
      default: snoop_inv = v;
    endcase
  endtask

  task automatic set_cfg(logic a, logic b, logic c);
    drain();
    write_cfg(CFG_SILENT_EVICT, a);
    write_cfg(CFG_EXPECT_WBACK, b);
    write_cfg(CFG_SNOOP_INV, c);
    cfg_we <= 1'b0;
  endtask

  function automatic in_t rand_request(logic [3:0] op, logic [7:0] line);
    in_t r;
    r = in_t'($bits(in_t)'($urandom));
    r.op = op;
    r.line_index = line;
    r.line_present = $urandom_range(99) < 85;
    return r;
  endfunction

  task automatic test_directed();
    in_t r;
    logic [3:0] op;
    // every op code on line 0, then ops on lines 255 and 0 with extreme field values
    for (int k = 0; k < 16; k++) begin
      op = 4'(k);
      r = '0; r.op = op; r.line_present = 1'b1;
      send_request(r);
    end
    r = '1; r.op = OP_GETS; send_request(r);
    r = '1; r.op = OP_DATARESP; r.granted_state = 2'd3; send_request(r);
    r = '1; r.op = OP_GETX; send_request(r);           // GETX with unlock set, but the line is shared: a miss
    r = '1; r.op = OP_EVICT; send_request(r);
    r = '0; r.op = OP_INV; r.line_index = 8'hff; send_request(r);
    r = '0; r.op = OP_DATARESP; send_request(r);        // absent line
    r = '0; r.op = OP_FLUSH; r.request_pending = 1'b1; send_request(r);
  endtask

  // well-formed transactions on a pool of lines, with random noise mixed in
  task automatic test_random(int n, int pool);
    in_t r;
    logic [7:0] line;
    logic [3:0] op;
    int pick;
    for (int k = 0; k < n; k++) begin
      line = (pool == 256) ? 8'($urandom) : 8'($urandom_range(pool - 1));
      pick = $urandom_range(99);
      if (pick < 10) op = 4'($urandom_range(15));
      else if (pick < 40) begin
        case (line_st[line])
          LS_IS, LS_IM, LS_SM: op = OP_DATARESP;
          LS_SB, LS_IB: op = OP_FLUSHRESP;
          default: op = 4'($urandom_range(OP_GETSEX));
        endcase
      end else op = 4'($urandom_range(OP_EVICT));
      r = rand_request(op, line);
      if (op == OP_DATARESP && $urandom_range(1)) r.store_unlock = 1'b0;
      if ((op == OP_FLUSH || op == OP_FLUSHINV) && $urandom_range(3) != 0)
        r.request_pending = 1'b0;
      send_request(r);
    end
  endtask

  // drive one line's lock count up to saturation, then unlock it three times
  task automatic test_lock_saturation();
    in_t r;
    r = '0; r.op = OP_GETX; r.line_index = 8'd200; r.line_present = 1'b1;
    send_request(r);
    r.op = OP_DATARESP; r.orig_request = ORIG_GETX; send_request(r);
    r = '0; r.op = OP_GETSEX; r.line_index = 8'd200; r.line_present = 1'b1;
    repeat (258) send_request(r);
    r.op = OP_FETCHINV; send_request(r);
    r.op = OP_EVICT; send_request(r);
    r.op = OP_GETX; r.store_unlock = 1'b1;
    repeat (3) send_request(r);
  endtask

  initial begin
    for (int k = 0; k < 256; k++) begin
      line_st[k] = LS_I; locks[k] = '0; link_f[k] = 1'b0;
      lock_wait[k] = 1'b0; wb_pend[k] = 1'b0;
    end
    silent_evict = 1'b0; expect_wback = 1'b0; snoop_inv = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_cfg(1'b1, 1'b1, 1'b1);
    test_random(40, 8);
    set_cfg(1'b0, 1'b1, 1'b0);
    gap_pct = 0;
    test_random(30, 4);
    gap_pct = 35;
    set_cfg(1'b1, 1'b0, 1'b1);
    test_lock_saturation();
    test_random(30, 256);
    set_cfg(1'b0, 1'b0, 1'b0);
    test_random(30, 16);
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

>>> l1_mesi_line_controller_top.f
sv/mlc_pkg.sv
sv/mlc_ctrl.sv
sv/mlc_dpath.sv
sv/l1_mesi_line_controller_top.sv
tb/tb_top.sv
